/* rtl/clpb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clpb_pkg
// Shared types and constants of the point light cluster binning block.
// ----------------------------------------------------------------------------
package clpb_pkg;

  localparam int CW          = 20;
  localparam int MW          = CW + 1;
  localparam int PRODW       = 2 * MW;
  localparam int DISTW       = 44;
  localparam int MAX_RESULTS = 64;
  localparam int CNTW        = $clog2(MAX_RESULTS + 1);
  localparam int PLANEW      = 4 * CW;
  localparam int BOXW        = 6 * CW;

  localparam logic [1:0] KIND_PLANE = 2'd0;
  localparam logic [1:0] KIND_BOX   = 2'd1;
  localparam logic [1:0] KIND_TEST  = 2'd2;

  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] REG_DIV_X = 2'd0;
  localparam logic [1:0] REG_DIV_Y = 2'd1;
  localparam logic [1:0] REG_DIV_Z = 2'd2;

  localparam logic [2:0] DIV_RESET = 3'd4;

  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           axis;
    logic [5:0]           slot;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
    logic signed [CW-1:0] aux_x;
    logic signed [CW-1:0] aux_y;
    logic signed [CW-1:0] aux_z;
    logic [7:0]           light_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_light_id;
    logic [5:0] cluster_index;
    logic       touched;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_PLANE = 2'd0,
    OP_BOX   = 2'd1,
    OP_TEST  = 2'd2
  } op_e;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/cluster_point_light_binning.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_point_light_binning
// Bins a point light into view-frustum clusters.
//
// Input channel (in_valid_i/in_ready_o, in_item_t): plane loads, cluster box
// loads and light test requests. A two-entry queue decouples intake from the
// engine, so requests are taken while a result waits at the output.
// Output channel (out_valid_o/out_ready_i, out_item_t): one result per lit
// cluster in index order, the final one flagged last; a miss gives a single
// result with touched low and last high.
// Loads are written to the tables straight from idle. A test sweeps P plane
// probes (at most 2*(div+1) per axis), then tests the C clusters in the
// index ranges; both steps use the shared multiply-accumulate unit, one
// product per cycle, and the registered table reads.
// A stalled receiver holds the engine at its next result; the queue keeps
// taking requests until full.
// Reset clears control state and sets div_x, div_y, div_z to 4; the plane and
// box tables hold nothing until loaded.
// ----------------------------------------------------------------------------
module cluster_point_light_binning
  import clpb_pkg::*;
#(
  parameter int MAX_DIV      = 4,
  parameter int MAX_CLUSTERS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0] div_x_q, div_x_d, div_y_q, div_y_d, div_z_q, div_z_d;
  logic [2:0] wval;
  logic       wr;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;

  function automatic logic [2:0] clamp_div(logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (int'(v) > MAX_DIV) begin
      r = 3'(MAX_DIV);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign wval   = clamp_div(pwdata[2:0]);

  always_comb begin
    div_x_d = div_x_q;
    div_y_d = div_y_q;
    div_z_d = div_z_q;
    if (wr) begin
      unique case (paddr[3:2])
        REG_DIV_X: div_x_d = wval;
        REG_DIV_Y: div_y_d = wval;
        REG_DIV_Z: div_z_d = wval;
        default:   div_x_d = div_x_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIV_X: prdata = {29'b0, div_x_q};
      REG_DIV_Y: prdata = {29'b0, div_y_q};
      REG_DIV_Z: prdata = {29'b0, div_z_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_x_q <= DIV_RESET;
      div_y_q <= DIV_RESET;
      div_z_q <= DIV_RESET;
    end else begin
      div_x_q <= div_x_d;
      div_y_q <= div_y_d;
      div_z_q <= div_z_d;
    end
  end

  clpb_front #(.MAX_DIV(MAX_DIV), .MAX_CLUSTERS(MAX_CLUSTERS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  clpb_back #(.MAX_DIV(MAX_DIV), .MAX_CLUSTERS(MAX_CLUSTERS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .div_x_i     (div_x_q),
    .div_y_i     (div_y_q),
    .div_z_i     (div_z_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

/* rtl/clpb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clpb_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/clpb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clpb_front
// Request intake: classify, drop malformed loads and unknown kinds, queue commands.
// ----------------------------------------------------------------------------
module clpb_front
  import clpb_pkg::*;
#(
  parameter int MAX_DIV      = 4,
  parameter int MAX_CLUSTERS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  cmd_t       q_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, keep;
  cmd_t       cmd_new;

  always_comb begin
    keep        = 1'b0;
    cmd_new.op  = OP_TEST;
    cmd_new.item = in_item_i;
    unique case (in_item_i.kind)
      KIND_PLANE: begin
        cmd_new.op = OP_PLANE;
        keep = (in_item_i.axis <= AXIS_Z) && (int'(in_item_i.slot) <= MAX_DIV);
      end
      KIND_BOX: begin
        cmd_new.op = OP_BOX;
        keep = int'(in_item_i.slot) < MAX_CLUSTERS;
      end
      KIND_TEST: begin
        cmd_new.op = OP_TEST;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

/* rtl/clpb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clpb_back
// Command engine: table loads, plane sweeps, sphere-box tests, result output.
// ----------------------------------------------------------------------------
module clpb_back
  import clpb_pkg::*;
#(
  parameter int MAX_DIV      = 4,
  parameter int MAX_CLUSTERS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  wire cmd_t       cmd_i,
  input  wire logic [2:0] div_x_i,
  input  wire logic [2:0] div_y_i,
  input  wire logic [2:0] div_z_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);

  localparam int NPL  = 3 * (MAX_DIV + 1);
  localparam int PAW  = (NPL > 1) ? $clog2(NPL) : 1;
  localparam int BAW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW   = ($clog2(MAX_DIV + 1) > 3) ? $clog2(MAX_DIV + 1) : 3;
  localparam int IDXW = 3 * DW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PRD    = 10'b0000000010,
    S_PWT    = 10'b0000000100,
    S_MAC    = 10'b0000001000,
    S_PCMP   = 10'b0000010000,
    S_CSTART = 10'b0000100000,
    S_CIDX   = 10'b0001000000,
    S_CWT    = 10'b0010000000,
    S_BCMP   = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CW-1:0]    c_q [3], c_d [3];
  logic signed [CW-1:0]    r_q, r_d;
  logic [7:0]              lid_q, lid_d;
  logic [1:0]              axis_q, axis_d;
  logic [DW-1:0]           pi_q, pi_d, x0_q, x0_d;
  logic                    up_q, up_d;
  logic [DW-1:0]           lo_q [3], lo_d [3], hi_q [3], hi_d [3];
  logic [DW-1:0]           ci_q, ci_d, cj_q, cj_d, ck_q, ck_d;
  logic [5:0]              idx_q, idx_d, pend_idx_q, pend_idx_d;
  logic                    pend_v_q, pend_v_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  logic [2:0]              t_q, t_d;
  logic signed [PRODW-1:0] prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic signed [DISTW-1:0] acc_q, acc_d;
  logic                    is_box_q, is_box_d;
  logic signed [MW-1:0]    d_q [3], d_d [3];
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic                    plane_we, plane_re, box_we, box_re, out_load, out_free;
  logic [PAW-1:0]          plane_waddr, plane_raddr;
  logic [BAW-1:0]          box_waddr, box_raddr;
  logic [PLANEW-1:0]       plane_wdata, plane_rdata;
  logic [BOXW-1:0]         box_wdata, box_rdata;

  logic signed [CW-1:0]    pn [3];
  logic signed [CW-1:0]    poff;
  logic signed [CW-1:0]    bl [3], bh [3];
  logic signed [MW-1:0]    dlt [3];
  logic signed [MW-1:0]    mul_a, mul_b;
  logic                    mul_neg;
  logic [2:0]              nterms;
  logic signed [DISTW-1:0] prod_ext, rs, ndist;
  logic [DW-1:0]           dx, dy, dz, pm1;
  logic [DW:0]             pi_inc;
  logic [IDXW-1:0]         idx, dxy;
  logic                    idx_ok, hit, stall;
  logic [DW-1:0]           adv_ci, adv_cj, adv_ck;
  logic                    adv_done;

  clpb_ram #(.WIDTH(PLANEW), .DEPTH(NPL)) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (plane_we),
    .waddr_i (plane_waddr),
    .wdata_i (plane_wdata),
    .re_i    (plane_re),
    .raddr_i (plane_raddr),
    .rdata_o (plane_rdata)
  );

  clpb_ram #(.WIDTH(BOXW), .DEPTH(MAX_CLUSTERS)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (box_waddr),
    .wdata_i (box_wdata),
    .re_i    (box_re),
    .raddr_i (box_raddr),
    .rdata_o (box_rdata)
  );

  assign plane_waddr = PAW'(32'(cmd_i.item.axis) * (MAX_DIV + 1) + 32'(cmd_i.item.slot));
  assign plane_raddr = PAW'(32'(axis_q) * (MAX_DIV + 1) + 32'(pi_q));
  assign plane_wdata = {cmd_i.item.vec_x, cmd_i.item.vec_y, cmd_i.item.vec_z,
                        cmd_i.item.aux_x};
  assign box_waddr   = BAW'(cmd_i.item.slot);
  assign box_raddr   = BAW'(idx);
  assign box_wdata   = {cmd_i.item.vec_x, cmd_i.item.vec_y, cmd_i.item.vec_z,
                        cmd_i.item.aux_x, cmd_i.item.aux_y, cmd_i.item.aux_z};

  assign pn[0] = plane_rdata[79:60];
  assign pn[1] = plane_rdata[59:40];
  assign pn[2] = plane_rdata[39:20];
  assign poff  = plane_rdata[19:0];
  assign bl[0] = box_rdata[119:100];
  assign bl[1] = box_rdata[99:80];
  assign bl[2] = box_rdata[79:60];
  assign bh[0] = box_rdata[59:40];
  assign bh[1] = box_rdata[39:20];
  assign bh[2] = box_rdata[19:0];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (c_q[a] < bl[a]) begin
        dlt[a] = {c_q[a][CW-1], c_q[a]} - {bl[a][CW-1], bl[a]};
      end else if (c_q[a] > bh[a]) begin
        dlt[a] = {c_q[a][CW-1], c_q[a]} - {bh[a][CW-1], bh[a]};
      end else begin
        dlt[a] = '0;
      end
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    nterms  = is_box_q ? 3'd4 : 3'd3;
    if (!is_box_q) begin
      unique case (t_q)
        3'd0: begin
          mul_a = {pn[0][CW-1], pn[0]};
          mul_b = {c_q[0][CW-1], c_q[0]};
        end
        3'd1: begin
          mul_a = {pn[1][CW-1], pn[1]};
          mul_b = {c_q[1][CW-1], c_q[1]};
        end
        3'd2: begin
          mul_a = {pn[2][CW-1], pn[2]};
          mul_b = {c_q[2][CW-1], c_q[2]};
        end
        default: mul_a = '0;
      endcase
    end else begin
      unique case (t_q)
        3'd0: begin
          mul_a = {r_q[CW-1], r_q};
          mul_b = {r_q[CW-1], r_q};
        end
        3'd1: begin
          mul_a   = d_q[0];
          mul_b   = d_q[0];
          mul_neg = 1'b1;
        end
        3'd2: begin
          mul_a   = d_q[1];
          mul_b   = d_q[1];
          mul_neg = 1'b1;
        end
        3'd3: begin
          mul_a   = d_q[2];
          mul_b   = d_q[2];
          mul_neg = 1'b1;
        end
        default: mul_a = '0;
      endcase
    end
  end

  assign prod_ext = {{(DISTW-PRODW){prod_q[PRODW-1]}}, prod_q};
  assign rs       = {{(DISTW-CW-14){r_q[CW-1]}}, r_q, 14'b0};
  assign ndist    = -acc_q;

  assign dx  = DW'(div_x_i);
  assign dy  = DW'(div_y_i);
  assign dz  = DW'(div_z_i);
  assign dxy = IDXW'(dx) * IDXW'(dy);
  assign idx = IDXW'(ci_q) + IDXW'(cj_q) * IDXW'(dx) + IDXW'(ck_q) * dxy;
  assign idx_ok = (32'(idx) < MAX_CLUSTERS) && (cnt_q < CNTW'(MAX_RESULTS));
  assign pi_inc = {1'b0, pi_q} + 1'b1;

  always_comb begin
    unique case (axis_q)
      2'd0:    pm1 = dx;
      2'd1:    pm1 = dy;
      default: pm1 = dz;
    endcase
  end

  always_comb begin
    adv_ci   = ci_q;
    adv_cj   = cj_q;
    adv_ck   = ck_q;
    adv_done = 1'b0;
    if ({1'b0, ci_q} + 1'b1 < {1'b0, hi_q[0]}) begin
      adv_ci = ci_q + 1'b1;
    end else begin
      adv_ci = lo_q[0];
      if ({1'b0, cj_q} + 1'b1 < {1'b0, hi_q[1]}) begin
        adv_cj = cj_q + 1'b1;
      end else begin
        adv_cj = lo_q[1];
        if ({1'b0, ck_q} + 1'b1 < {1'b0, hi_q[2]}) begin
          adv_ck = ck_q + 1'b1;
        end else begin
          adv_done = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign hit      = acc_q > 0;
  assign stall    = hit && pend_v_q && !out_free;

  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    r_d        = r_q;
    lid_d      = lid_q;
    axis_d     = axis_q;
    pi_d       = pi_q;
    x0_d       = x0_q;
    up_d       = up_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    ci_d       = ci_q;
    cj_d       = cj_q;
    ck_d       = ck_q;
    idx_d      = idx_q;
    pend_idx_d = pend_idx_q;
    pend_v_d   = pend_v_q;
    cnt_d      = cnt_q;
    t_d        = t_q;
    prod_d     = prod_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    is_box_d   = is_box_q;
    d_d        = d_q;
    out_d      = out_q;
    out_load   = 1'b0;
    plane_we   = 1'b0;
    plane_re   = 1'b0;
    box_we     = 1'b0;
    box_re     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_PLANE: plane_we = 1'b1;
            OP_BOX:   box_we   = 1'b1;
            OP_TEST: begin
              c_d[0]   = cmd_i.item.vec_x;
              c_d[1]   = cmd_i.item.vec_y;
              c_d[2]   = cmd_i.item.vec_z;
              r_d      = cmd_i.item.aux_x;
              lid_d    = cmd_i.item.light_id;
              axis_d   = '0;
              pi_d     = '0;
              up_d     = 1'b1;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              is_box_d = 1'b0;
              state_d  = S_PRD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PRD: begin
        plane_re = 1'b1;
        state_d  = S_PWT;
      end
      S_PWT: begin
        acc_d   = {{(DISTW-CW-14){poff[CW-1]}}, poff, 14'b0};
        t_d     = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        if (t_q < nterms) begin
          prod_d = mul_a * mul_b;
          neg_d  = mul_neg;
        end
        if (t_q != 3'd0) begin
          acc_d = neg_q ? acc_q - prod_ext : acc_q + prod_ext;
        end
        t_d = t_q + 1'b1;
        if (t_q == nterms) begin
          state_d = is_box_q ? S_BCMP : S_PCMP;
        end
      end
      S_PCMP: begin
        state_d = S_PRD;
        if (up_q) begin
          if (acc_q < rs) begin
            x0_d = (pi_q == '0) ? '0 : pi_q - 1'b1;
            up_d = 1'b0;
            pi_d = pm1;
          end else if (pi_q == pm1) begin
            state_d = S_FIN;
          end else begin
            pi_d = pi_q + 1'b1;
          end
        end else begin
          if (ndist < rs) begin
            lo_d[axis_q] = x0_q;
            hi_d[axis_q] = (pi_inc < {1'b0, pm1}) ? pi_inc[DW-1:0] : pm1;
            if (axis_q == AXIS_Z) begin
              state_d = S_CSTART;
            end else begin
              axis_d = axis_q + 1'b1;
              up_d   = 1'b1;
              pi_d   = '0;
            end
          end else if (pi_q == x0_q) begin
            state_d = S_FIN;
          end else begin
            pi_d = pi_q - 1'b1;
          end
        end
      end
      S_CSTART: begin
        ci_d = lo_q[0];
        cj_d = lo_q[1];
        ck_d = lo_q[2];
        if ((lo_q[0] >= hi_q[0]) || (lo_q[1] >= hi_q[1]) || (lo_q[2] >= hi_q[2])) begin
          state_d = S_FIN;
        end else begin
          state_d = S_CIDX;
        end
      end
      S_CIDX: begin
        idx_d = idx[5:0];
        if (idx_ok) begin
          box_re  = 1'b1;
          state_d = S_CWT;
        end else begin
          ci_d    = adv_ci;
          cj_d    = adv_cj;
          ck_d    = adv_ck;
          state_d = adv_done ? S_FIN : S_CIDX;
        end
      end
      S_CWT: begin
        d_d      = dlt;
        acc_d    = '0;
        t_d      = '0;
        is_box_d = 1'b1;
        state_d  = S_MAC;
      end
      S_BCMP: begin
        if (!stall) begin
          if (hit) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              out_d    = '{out_light_id: lid_q, cluster_index: pend_idx_q,
                           touched: 1'b1, last: 1'b0};
            end
            pend_v_d   = 1'b1;
            pend_idx_d = idx_q;
            cnt_d      = cnt_q + 1'b1;
          end
          ci_d    = adv_ci;
          cj_d    = adv_cj;
          ck_d    = adv_ck;
          state_d = adv_done ? S_FIN : S_CIDX;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = pend_v_q ?
                     '{out_light_id: lid_q, cluster_index: pend_idx_q,
                       touched: 1'b1, last: 1'b1} :
                     '{out_light_id: lid_q, cluster_index: 6'd0,
                       touched: 1'b0, last: 1'b1};
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_v_q    <= pend_v_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    r_q        <= r_d;
    lid_q      <= lid_d;
    axis_q     <= axis_d;
    pi_q       <= pi_d;
    x0_q       <= x0_d;
    up_q       <= up_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    ci_q       <= ci_d;
    cj_q       <= cj_d;
    ck_q       <= ck_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    t_q        <= t_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    acc_q      <= acc_d;
    is_box_q   <= is_box_d;
    d_q        <= d_d;
    out_q      <= out_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == S_CIDX || state_q == S_CWT || state_q == S_MAC ||
                  state_q == S_BCMP || state_q == S_FIN))
    else $error("pending hit outside cluster scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_RESULTS))
    else $error("hit count over limit");

  a_fin_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=>
      (state_q == S_IDLE && !pend_v_q && out_valid_q && out_q.last))
    else $error("test did not close with a last result");

  a_mid_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> out_q.touched)
    else $error("non-final result without a hit");
`endif

endmodule
`default_nettype wire

/* bench/tb_cluster_point_light_binning.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_point_light_binning
// Self-checking bench for the point light cluster binning block: loads a
// regular cluster grid, sends directed and random light tests, plane and box
// loads under several division settings and handshake stall patterns, and
// checks every result against an in-bench model of the binning.
// ----------------------------------------------------------------------------
module tb_cluster_point_light_binning;
  import clpb_pkg::*;

  localparam int LIMIT      = 2_000_000;
  localparam int MAXDIV     = 4;
  localparam int NCLUSTERS  = 64;
  localparam int GRID_STEP  = 2048;
  localparam int GRID_BASE  = -4096;
  localparam int UNIT_NRM   = 16384;
  localparam int DRAIN_WAIT = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cluster_point_light_binning dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  int nrm [3][MAXDIV+1][3];
  int ofs [3][MAXDIV+1];
  int blo [NCLUSTERS][3];
  int bhi [NCLUSTERS][3];
  int dv  [3];

  out_item_t pending_hits[$];
  int        mismatches = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("cluster_point_light_binning regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  out_item_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: got %p", out_item_o);
      end else begin
        want = pending_hits.pop_front();
        if (out_item_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_item_o);
        end
      end
    end
  end

  function automatic longint plane_dist(int a, int i, int c[3]);
    return longint'(nrm[a][i][0]) * c[0] + longint'(nrm[a][i][1]) * c[1]
         + longint'(nrm[a][i][2]) * c[2] + longint'(ofs[a][i]) * 16384;
  endfunction

  function automatic bit sweep_axis(int a, int c[3], longint r, output int lo,
                                    output int hi);
    int planes;
    int x0;
    int x1;
    planes = dv[a] + 1;
    x0 = -1;
    x1 = -1;
    lo = 0;
    hi = 0;
    for (int i = 0; i < planes; i++) begin
      if (plane_dist(a, i, c) < r) begin
        x0 = (i > 0) ? i - 1 : 0;
        break;
      end
    end
    if (x0 < 0) return 1'b0;
    for (int i = planes - 1; i >= x0; i--) begin
      if (-plane_dist(a, i, c) < r) begin
        x1 = (i + 1 < planes - 1) ? i + 1 : planes - 1;
        break;
      end
    end
    if (x1 < 0) return 1'b0;
    lo = x0;
    hi = x1;
    return 1'b1;
  endfunction

  function automatic bit sphere_hits_box(int idx, int c[3], int r);
    longint d2;
    longint d;
    d2 = longint'(r) * r;
    for (int a = 0; a < 3; a++) begin
      d = 0;
      if (c[a] < blo[idx][a]) d = longint'(c[a]) - blo[idx][a];
      else if (c[a] > bhi[idx][a]) d = longint'(c[a]) - bhi[idx][a];
      d2 -= d * d;
    end
    return d2 > 0;
  endfunction

  task automatic queue_result(out_item_t r);
    pending_hits.insert(pending_hits.size(), r);
  endtask

  task automatic bin_light(in_item_t it);
    int c[3];
    int w[3];
    int lo[3];
    int hi[3];
    int n;
    int idx;
    bit any;
    c[0] = int'(it.vec_x); c[1] = int'(it.vec_y); c[2] = int'(it.vec_z);
    w[0] = int'(it.aux_x); w[1] = int'(it.aux_y); w[2] = int'(it.aux_z);
    n = 0;
    case (it.kind)
      KIND_PLANE: begin
        if (it.axis <= AXIS_Z && int'(it.slot) <= MAXDIV) begin
          for (int a = 0; a < 3; a++) nrm[it.axis][it.slot][a] = c[a];
          ofs[it.axis][it.slot] = w[0];
        end
      end
      KIND_BOX: begin
        for (int a = 0; a < 3; a++) begin
          blo[it.slot][a] = c[a];
          bhi[it.slot][a] = w[a];
        end
      end
      KIND_TEST: begin
        any = 1'b1;
        for (int a = 0; a < 3 && any; a++)
          any = sweep_axis(a, c, longint'(w[0]) * 16384, lo[a], hi[a]);
        if (any) begin
          for (int k = lo[2]; k < hi[2]; k++)
            for (int j = lo[1]; j < hi[1]; j++)
              for (int i = lo[0]; i < hi[0]; i++) begin
                idx = i + j * dv[0] + k * dv[0] * dv[1];
                if (n >= MAX_RESULTS || idx >= NCLUSTERS) continue;
                if (!sphere_hits_box(idx, c, w[0])) continue;
                queue_result('{it.light_id, idx[5:0], 1'b1, 1'b0});
                n++;
              end
        end
        if (n == 0) queue_result('{it.light_id, 6'd0, 1'b0, 1'b1});
        else pending_hits[pending_hits.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bin_light(it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_div(logic [1:0] idx, logic [31:0] val);
    int u;
    u = int'(val[2:0]);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx <= REG_DIV_Z) dv[idx] = (u < 1) ? 1 : (u > MAXDIV) ? MAXDIV : u;
  endtask

  function automatic in_item_t grid_plane(int a, int i);
    in_item_t it;
    it = '0;
    it.kind = KIND_PLANE;
    it.axis = a[1:0];
    it.slot = i[5:0];
    it.vec_x = CW'((a == 0) ? UNIT_NRM : 0);
    it.vec_y = CW'((a == 1) ? UNIT_NRM : 0);
    it.vec_z = CW'((a == 2) ? UNIT_NRM : 0);
    it.aux_x = CW'(-(GRID_BASE + i * GRID_STEP));
    return it;
  endfunction

  function automatic in_item_t grid_box(int s, int jitter);
    in_item_t it;
    it = '0;
    it.kind = KIND_BOX;
    it.slot = s[5:0];
    it.vec_x = CW'(GRID_BASE + (s % 4) * GRID_STEP - int'($urandom_range(jitter)));
    it.vec_y = CW'(GRID_BASE + ((s / 4) % 4) * GRID_STEP - int'($urandom_range(jitter)));
    it.vec_z = CW'(GRID_BASE + (s / 16) * GRID_STEP - int'($urandom_range(jitter)));
    it.aux_x = CW'(GRID_BASE + (s % 4 + 1) * GRID_STEP + int'($urandom_range(jitter)));
    it.aux_y = CW'(GRID_BASE + ((s / 4) % 4 + 1) * GRID_STEP
                   + int'($urandom_range(jitter)));
    it.aux_z = CW'(GRID_BASE + (s / 16 + 1) * GRID_STEP + int'($urandom_range(jitter)));
    return it;
  endfunction

  function automatic in_item_t light(int cx, int cy, int cz, int r);
    in_item_t it;
    it = '0;
    it.kind = KIND_TEST;
    it.vec_x = CW'(cx); it.vec_y = CW'(cy); it.vec_z = CW'(cz);
    it.aux_x = CW'(r);
    it.aux_y = CW'($urandom);
    it.aux_z = CW'($urandom);
    it.light_id = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = '0;
    it.kind = 2'($urandom);
    it.axis = 2'($urandom);
    it.slot = 6'($urandom);
    it.vec_x = CW'($urandom); it.vec_y = CW'($urandom); it.vec_z = CW'($urandom);
    it.aux_x = CW'($urandom); it.aux_y = CW'($urandom); it.aux_z = CW'($urandom);
    it.light_id = 8'($urandom);
    return it;
  endfunction

  task automatic test_load_grid();
    for (int a = 0; a < 3; a++)
      for (int i = 0; i <= MAXDIV; i++) send_request(grid_plane(a, i));
    for (int s = 0; s < NCLUSTERS; s++) send_request(grid_box(s, 0));
    end_burst();
  endtask

  task automatic test_directed();
    in_item_t it;
    send_request(light(0, 0, 0, 20000));
    send_request(light(0, 0, 0, 0));
    send_request(light(100, -300, 500, 1));
    send_request(light(-524288, -524288, -524288, 524287));
    send_request(light(524287, 524287, 524287, 524287));
    send_request(light(524287, 0, 0, 100));
    send_request(light(-3000, 2500, 1000, 900));
    end_burst();
    wait_drained();
    it = noise_item();
    it.kind = 2'd3;
    send_request(it);
    it = grid_plane(0, 2);
    it.axis = 2'd3;
    it.vec_x = -524288;
    send_request(it);
    it = grid_plane(1, 2);
    it.slot = 6'd63;
    it.aux_x = 524287;
    send_request(it);
    send_request(light(2000, 2000, 2000, 1500));
    end_burst();
    wait_drained();
    write_div(REG_DIV_X, 32'd1);
    write_div(REG_DIV_Y, 32'd0);
    write_div(REG_DIV_Z, 32'hFFFF_FFFF);
    write_div(2'd3, 32'd2);
    send_request(light(0, 0, 0, 20000));
    send_request(light(-5000, 5000, 0, 3000));
    end_burst();
    wait_drained();
  endtask

  task automatic test_random_phase(int idle, int stall, int count, bit [2:0] dx,
                                   bit [2:0] dy, bit [2:0] dz);
    int pick;
    write_div(REG_DIV_X, {29'd0, dx});
    write_div(REG_DIV_Y, {29'd0, dy});
    write_div(REG_DIV_Z, {29'd0, dz});
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 78)
        send_request(light($signed($urandom_range(12000)) - 6000,
                           $signed($urandom_range(12000)) - 6000,
                           $signed($urandom_range(12000)) - 6000,
                           $urandom_range(3000)));
      else if (pick < 86)
        send_request(grid_box($urandom_range(NCLUSTERS - 1), 600));
      else if (pick < 92)
        send_request(grid_plane($urandom_range(2), $urandom_range(MAXDIV)));
      else
        send_request(noise_item());
    end
    end_burst();
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    dv[0] = 4; dv[1] = 4; dv[2] = 4;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_grid();
    test_directed();
    test_random_phase(0, 0, 20, 3'd4, 3'd4, 3'd4);
    test_random_phase(83, 0, 20, 3'd1, 3'd1, 3'd1);
    test_random_phase(0, 83, 20, 3'd2, 3'd3, 3'd4);
    test_random_phase(26, 26, 20, 3'($urandom), 3'($urandom), 3'($urandom));
    test_random_phase(0, 0, 20, 3'($urandom), 3'($urandom), 3'($urandom));
    wait_drained();
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("cluster_point_light_binning regression: pass");
    end else begin
      $display("cluster_point_light_binning regression: fail");
    end
    $finish;
  end

endmodule
